@@ design/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TLB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define TLB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tlbac_pkg.sv @@
// Types, constants and helpers shared by the two-level block allocator.
package tlbac_pkg;

    localparam int NUM_BLOCKS  = 64;
    localparam int NUM_CLIENTS = 4;
    localparam int MAX_TARGET  = 4;
    localparam int LOCAL_CAP   = 2 * MAX_TARGET;
    localparam int LOCAL_DEPTH = NUM_CLIENTS * LOCAL_CAP;

    // Field widths fixed by the request and response formats
    localparam int OP_W     = 1;
    localparam int CLIENT_W = 2;
    localparam int BLK_W    = 6;
    localparam int STATUS_W = 2;
    localparam int TF_W     = 3;

    // Storage widths
    localparam int GADDR_W = $clog2(NUM_BLOCKS);
    localparam int GCNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int LIDX_W  = $clog2(LOCAL_CAP);
    localparam int LADDR_W = $clog2(LOCAL_DEPTH);
    localparam int LCNT_W  = $clog2(LOCAL_CAP + 1);

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    localparam logic [TF_W-1:0] TARGET_FILL_RESET = 3'd3;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [CLIENT_W-1:0] client;
        logic [BLK_W-1:0]    block_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    block_out;
    } rsp_t;

    // Global stack access from the sequencer
    typedef struct packed {
        logic               rd_en;
        logic [GADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [GADDR_W-1:0] wr_addr;
        logic [BLK_W-1:0]   wr_data;
    } gmem_req_t;

    // Local stack access from the sequencer
    typedef struct packed {
        logic               rd_en;
        logic [LADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [LADDR_W-1:0] wr_addr;
        logic [BLK_W-1:0]   wr_data;
    } lmem_req_t;

    // Clamp the programmed fill target into 1..MAX_TARGET
    function automatic logic [LCNT_W-1:0] eff_target(input logic [TF_W-1:0] t);
        logic [LCNT_W-1:0] r;
        if (t == '0)
            r = LCNT_W'(1);
        else if (int'(t) > MAX_TARGET)
            r = LCNT_W'(MAX_TARGET);
        else
            r = LCNT_W'(t);
        return r;
    endfunction

endpackage

@@ design/two_level_block_allocator_cache.sv @@
// Top level of the two-level free-block allocator.
//
// Requests arrive on req (valid/ready): opcode allocate or free, client number
// and, for a free, the block index. Each request yields one response on rsp
// (valid/ready): status ok, empty or rejected, and the allocated block.
// cfg_we/cfg_data write target_fill, the refill size; a local stack holds up
// to twice that. Write it only while no request is in flight.
// One request is worked at a time; req_ready is high only between requests.
// A request that fails or is rejected at once goes straight to its response;
// otherwise, when the local stack cannot serve it directly, up to 7 blocks
// first move between the global and local stacks, and the move unit
// transfers one entry per cycle through the registered memory ports.
// The response sits in an output register, so a new request is taken while
// the last response waits; a stalled receiver holds the sequencer only when
// its next response is ready to load.
// Reset returns every block to the global stack (block i at entry i, highest
// on top), empties the local stacks and sets target_fill to 3.
module two_level_block_allocator_cache (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tlbac_pkg::TF_W-1:0] cfg_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  tlbac_pkg::req_t            req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output tlbac_pkg::rsp_t            rsp
);
    import tlbac_pkg::*;

    logic [TF_W-1:0]  target_fill_reg;
    gmem_req_t        greq;
    lmem_req_t        lreq;
    logic [BLK_W-1:0] gdata;
    logic [BLK_W-1:0] ldata;

    // Hold the fill target register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_fill_reg <= TARGET_FILL_RESET;
        end
        else if (cfg_we)
        begin
            target_fill_reg <= cfg_data;
        end
    end

    tlbac_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .target_fill (target_fill_reg),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .greq        (greq),
        .gdata       (gdata),
        .lreq        (lreq),
        .ldata       (ldata)
    );

    tlbac_gstack u_gstack (
        .clk   (clk),
        .rst_n (rst_n),
        .greq  (greq),
        .rdata (gdata)
    );

    tlbac_lstack u_lstack (
        .clk   (clk),
        .lreq  (lreq),
        .rdata (ldata)
    );

endmodule

@@ design/tlbac_gstack.sv @@
// Global free stack memory; an entry never written reads as its own index.
module tlbac_gstack (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlbac_pkg::gmem_req_t        greq,
    output logic [tlbac_pkg::BLK_W-1:0] rdata
);
    import tlbac_pkg::*;

    logic [BLK_W-1:0] mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [BLK_W-1:0] rdata_reg;

    // Track which entries hold written data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (greq.wr_en)
        begin
            valid_reg[greq.wr_addr] <= 1'b1;
        end
    end

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (greq.wr_en)
        begin
            mem[greq.wr_addr] <= greq.wr_data;
        end
        if (greq.rd_en)
        begin
            rdata_reg <= valid_reg[greq.rd_addr] ? mem[greq.rd_addr]
                                                 : BLK_W'(greq.rd_addr);
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tlbac_lstack.sv @@
// Per-client local stack memory, one slice of LOCAL_CAP entries per client.
module tlbac_lstack (
    input  logic                        clk,
    input  tlbac_pkg::lmem_req_t        lreq,
    output logic [tlbac_pkg::BLK_W-1:0] rdata
);
    import tlbac_pkg::*;

    logic [BLK_W-1:0] mem [LOCAL_DEPTH];
    logic [BLK_W-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (lreq.wr_en)
        begin
            mem[lreq.wr_addr] <= lreq.wr_data;
        end
        if (lreq.rd_en)
        begin
            rdata_reg <= mem[lreq.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tlbac_seq.sv @@
// Request sequencer: counters, one-entry-per-cycle move unit and response register.
`include "assert_macros.svh"

module tlbac_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tlbac_pkg::TF_W-1:0]  target_fill,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  tlbac_pkg::req_t             req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output tlbac_pkg::rsp_t             rsp,
    output tlbac_pkg::gmem_req_t        greq,
    input  logic [tlbac_pkg::BLK_W-1:0] gdata,
    output tlbac_pkg::lmem_req_t        lreq,
    input  logic [tlbac_pkg::BLK_W-1:0] ldata
);
    import tlbac_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MOVE,
        S_POP,
        S_PUSH,
        S_FINISH
    } state_t;

    localparam int SUM_W = GCNT_W + 1;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [CLIENT_W-1:0] client_reg, client_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [LCNT_W-1:0]   tf_reg, tf_next;
    logic [GCNT_W-1:0]   gcount_reg, gcount_next;
    logic [LCNT_W-1:0]   lcount_reg [NUM_CLIENTS];
    logic [LCNT_W-1:0]   lcount_next [NUM_CLIENTS];
    logic [LCNT_W-1:0]   issue_left_reg, issue_left_next;
    logic                pend_reg, pend_next;
    logic                spill_reg, spill_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [LCNT_W-1:0]   cur_lcnt;
    logic [LCNT_W-1:0]   lcnt_m1;
    logic [GCNT_W-1:0]   gcnt_m1;
    logic [LCNT_W-1:0]   spill_cnt;
    logic [LCNT_W-1:0]   refill_cnt;
    logic                spill_over;

    assign cur_lcnt   = lcount_reg[client_reg];
    assign lcnt_m1    = cur_lcnt - LCNT_W'(1);
    assign gcnt_m1    = gcount_reg - GCNT_W'(1);
    assign spill_cnt  = cur_lcnt - tf_reg;
    assign refill_cnt = (gcount_reg >= GCNT_W'(tf_reg)) ? tf_reg
                                                        : gcount_reg[LCNT_W-1:0];
    assign spill_over = (SUM_W'(gcount_reg) + SUM_W'(spill_cnt)) > SUM_W'(NUM_BLOCKS);

    // Sequence one request: decide, move entries, pop or push, respond
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        client_next     = client_reg;
        blk_next        = blk_reg;
        tf_next         = tf_reg;
        gcount_next     = gcount_reg;
        lcount_next     = lcount_reg;
        issue_left_next = issue_left_reg;
        pend_next       = pend_reg;
        spill_next      = spill_reg;
        status_next     = status_reg;
        rsp_next        = rsp_reg;
        greq            = '0;
        lreq            = '0;

        // Drop the response once taken
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    client_next = req.client;
                    blk_next    = req.block_in;
                    tf_next     = eff_target(target_fill);
                    state_next  = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (int'(client_reg) >= NUM_CLIENTS)
                begin
                    status_next = (op_reg == OP_FREE) ? ST_REJECT : ST_EMPTY;
                    state_next  = S_FINISH;
                end
                else if (op_reg == OP_ALLOC)
                begin
                    if (cur_lcnt != '0)
                    begin
                        state_next = S_POP;
                    end
                    else if (refill_cnt == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        issue_left_next = refill_cnt;
                        pend_next       = 1'b0;
                        spill_next      = 1'b0;
                        state_next      = S_MOVE;
                    end
                end
                else
                begin
                    if (cur_lcnt < (tf_reg << 1))
                    begin
                        state_next = S_PUSH;
                    end
                    else if (spill_over)
                    begin
                        status_next = ST_REJECT;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        issue_left_next = spill_cnt;
                        pend_next       = 1'b0;
                        spill_next      = 1'b1;
                        state_next      = S_MOVE;
                    end
                end
            end

            S_MOVE:
            begin
                // Issue one read per cycle, write the previous read's data
                if (!spill_reg)
                begin
                    if (issue_left_reg != '0)
                    begin
                        greq.rd_en      = 1'b1;
                        greq.rd_addr    = gcnt_m1[GADDR_W-1:0];
                        gcount_next     = gcnt_m1;
                        issue_left_next = issue_left_reg - LCNT_W'(1);
                    end
                    if (pend_reg)
                    begin
                        lreq.wr_en  = 1'b1;
                        lreq.wr_addr = {client_reg, cur_lcnt[LIDX_W-1:0]};
                        lreq.wr_data = gdata;
                        lcount_next[client_reg] = cur_lcnt + LCNT_W'(1);
                    end
                end
                else
                begin
                    if (issue_left_reg != '0)
                    begin
                        lreq.rd_en      = 1'b1;
                        lreq.rd_addr    = {client_reg, lcnt_m1[LIDX_W-1:0]};
                        lcount_next[client_reg] = lcnt_m1;
                        issue_left_next = issue_left_reg - LCNT_W'(1);
                    end
                    if (pend_reg)
                    begin
                        greq.wr_en   = 1'b1;
                        greq.wr_addr = gcount_reg[GADDR_W-1:0];
                        greq.wr_data = ldata;
                        gcount_next  = gcount_reg + GCNT_W'(1);
                    end
                end
                pend_next = (issue_left_reg != '0);
                if (issue_left_reg == '0)
                begin
                    state_next = spill_reg ? S_PUSH : S_POP;
                end
            end

            S_POP:
            begin
                lreq.rd_en   = 1'b1;
                lreq.rd_addr = {client_reg, lcnt_m1[LIDX_W-1:0]};
                lcount_next[client_reg] = lcnt_m1;
                status_next  = ST_OK;
                state_next   = S_FINISH;
            end

            S_PUSH:
            begin
                lreq.wr_en   = 1'b1;
                lreq.wr_addr = {client_reg, cur_lcnt[LIDX_W-1:0]};
                lreq.wr_data = blk_reg;
                lcount_next[client_reg] = cur_lcnt + LCNT_W'(1);
                status_next  = ST_OK;
                state_next   = S_FINISH;
            end

            S_FINISH:
            begin
                // Load the response once the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = status_reg;
                    rsp_next.block_out = (op_reg == OP_ALLOC && status_reg == ST_OK)
                                         ? ldata : '0;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, counters and the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_ALLOC;
            client_reg     <= '0;
            blk_reg        <= '0;
            tf_reg         <= LCNT_W'(1);
            gcount_reg     <= GCNT_W'(NUM_BLOCKS);
            for (int i = 0; i < NUM_CLIENTS; i++)
            begin
                lcount_reg[i] <= '0;
            end
            issue_left_reg <= '0;
            pend_reg       <= 1'b0;
            spill_reg      <= 1'b0;
            status_reg     <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            client_reg     <= client_next;
            blk_reg        <= blk_next;
            tf_reg         <= tf_next;
            gcount_reg     <= gcount_next;
            lcount_reg     <= lcount_next;
            issue_left_reg <= issue_left_next;
            pend_reg       <= pend_next;
            spill_reg      <= spill_next;
            status_reg     <= status_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on the sequencer
    `TLB_ASSERT(a_gcount_range, clk, rst_n, gcount_reg <= GCNT_W'(NUM_BLOCKS), "global count past capacity")
    `TLB_ASSERT(a_lcount_range, clk, rst_n, lcount_reg[client_reg] <= LCNT_W'(LOCAL_CAP), "local count past capacity")
    `TLB_ASSERT(a_gstack_one_way, clk, rst_n, !(greq.rd_en && greq.wr_en), "global stack read and written together")
    `TLB_ASSERT(a_idle_quiet, clk, rst_n, req_ready |-> (issue_left_reg == '0 && !pend_reg), "ready with moves outstanding")
    `TLB_ASSERT(a_pop_nonempty, clk, rst_n, (state_reg == S_POP) |-> (cur_lcnt != '0), "pop from empty local stack")

endmodule

@@ dv/two_level_block_allocator_cache_tb.sv @@
// Self-checking testbench for the two-level block allocator with a built-in stack predictor.
module two_level_block_allocator_cache_tb;

    import tlbac_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [TF_W-1:0]   cfg_data  = '0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;

    // Stimulus and expected responses
    req_t pending_requests[$];
    rsp_t predicted_responses[$];

    // Predicted allocator state
    logic [BLK_W-1:0] pool_stack [NUM_BLOCKS];
    int               pool_count;
    logic [BLK_W-1:0] client_stack [NUM_CLIENTS][LOCAL_CAP];
    int               client_count [NUM_CLIENTS];
    logic [TF_W-1:0]  fill_target = TARGET_FILL_RESET;

    // Run control and bookkeeping
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    logic rsp_blocked    = 1'b0;
    int   accepted_total = 0;
    int   responses_seen = 0;
    int   mismatches     = 0;
    int   refills        = 0;
    int   spills         = 0;
    int   failed_allocs  = 0;
    int   rejected_frees = 0;
    int   fill_settings  = 1;

    two_level_block_allocator_cache DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one request to the predicted state and return its response
    function automatic rsp_t allocator_step(input req_t r);
        rsp_t out;
        int   tf;
        int   c;
        int   n;
        int   spill;
        out = '0;
        c = int'(r.client);
        tf = int'(fill_target);
        if (tf < 1)
            tf = 1;
        if (tf > MAX_TARGET)
            tf = MAX_TARGET;
        if (c >= NUM_CLIENTS)
        begin
            out.status = (r.opcode == OP_FREE) ? ST_REJECT : ST_EMPTY;
            return out;
        end
        if (r.opcode == OP_ALLOC)
        begin
            // Refill an empty local stack from the pool top
            if (client_count[c] == 0)
            begin
                n = 0;
                while (n < tf && pool_count > 0)
                begin
                    pool_count--;
                    client_stack[c][n] = pool_stack[pool_count];
                    n++;
                end
                client_count[c] = n;
                if (n > 0)
                    refills++;
            end
            if (client_count[c] == 0)
            begin
                out.status = ST_EMPTY;
                failed_allocs++;
            end
            else
            begin
                client_count[c]--;
                out.status    = ST_OK;
                out.block_out = client_stack[c][client_count[c]];
            end
        end
        else
        begin
            // Spill everything above the target from a full local stack
            if (client_count[c] >= 2 * tf)
            begin
                spill = client_count[c] - tf;
                if (pool_count + spill > NUM_BLOCKS)
                begin
                    out.status = ST_REJECT;
                    rejected_frees++;
                    return out;
                end
                while (client_count[c] > tf)
                begin
                    client_count[c]--;
                    pool_stack[pool_count] = client_stack[c][client_count[c]];
                    pool_count++;
                end
                spills++;
            end
            if (client_count[c] < LOCAL_CAP)
            begin
                client_stack[c][client_count[c]] = r.block_in;
                client_count[c]++;
            end
            out.status = ST_OK;
        end
        return out;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("mismatch on response %0d: %s got %0d expected %0d",
                 responses_seen, what, got, want);
        mismatches++;
    endtask

    task automatic queue_req(input logic [OP_W-1:0] op, input int cl, input int blk);
        req_t r;
        r.opcode   = op;
        r.client   = CLIENT_W'(cl);
        r.block_in = BLK_W'(blk);
        pending_requests.push_back(r);
    endtask

    // Queue bursts that lean toward allocate, free or neither, mostly on one client
    task automatic queue_random(input int count);
        int left;
        int burst;
        int alloc_pct;
        int focus;
        int cl;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(40, 8);
            if (burst > left)
                burst = left;
            case ($urandom_range(2))
                0:       alloc_pct = 20;
                1:       alloc_pct = 50;
                default: alloc_pct = 85;
            endcase
            focus = $urandom_range(NUM_CLIENTS - 1);
            repeat (burst)
            begin
                cl = ($urandom_range(99) < 70) ? focus : $urandom_range(NUM_CLIENTS - 1);
                if ($urandom_range(99) < alloc_pct)
                    queue_req(OP_ALLOC, cl, $urandom_range(63));
                else
                    queue_req(OP_FREE, cl, $urandom_range(63));
            end
            left -= burst;
        end
    endtask

    // Hold until every request is accepted and answered
    task automatic wait_drained();
        while (pending_requests.size() != 0 || predicted_responses.size() != 0 || req_valid)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_fill_target(input logic [TF_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        fill_target = v;
        fill_settings++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Request driver: predict on acceptance, then offer the next request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                predicted_responses.push_back(allocator_step(req));
                accepted_total++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor: compare against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        rsp_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                responses_seen++;
                if (predicted_responses.size() == 0)
                    log_mismatch("unrequested response, status", int'(rsp.status), -1);
                else
                begin
                    want = predicted_responses.pop_front();
                    if (rsp.status !== want.status)
                        log_mismatch("status", int'(rsp.status), int'(want.status));
                    if (rsp.block_out !== want.block_out)
                        log_mismatch("block_out", int'(rsp.block_out), int'(want.block_out));
                end
            end
            rsp_ready <= !rsp_blocked && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stall the receiver for a long stretch while requests keep coming
    initial
    begin
        wait (accepted_total >= 400);
        @(posedge clk);
        rsp_blocked <= 1'b1;
        repeat (300) @(posedge clk);
        rsp_blocked <= 1'b0;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d requests outstanding", predicted_responses.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [TF_W-1:0] fill_plan [8];
        int              p;
        fill_plan = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd4};
        for (int i = 0; i < NUM_BLOCKS; i++)
            pool_stack[i] = BLK_W'(i);
        pool_count = NUM_BLOCKS;
        for (int i = 0; i < NUM_CLIENTS; i++)
            client_count[i] = 0;

        // Release reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Fill client 0 then overflow the full pool; refill client 1 three times
        @(negedge clk);
        send_idle_pct = 16;
        recv_idle_pct = 52;
        queue_req(OP_FREE, 0, 0);
        queue_req(OP_FREE, 0, 63);
        queue_req(OP_FREE, 0, 42);
        queue_req(OP_FREE, 0, 21);
        queue_req(OP_FREE, 0, 1);
        queue_req(OP_FREE, 0, 62);
        queue_req(OP_FREE, 0, 31);
        repeat (7)
            queue_req(OP_ALLOC, 1, 63);
        queue_req(OP_ALLOC, 0, 0);
        wait_drained();

        // Fill client 2 to the largest capacity
        write_fill_target(3'd4);
        @(negedge clk);
        for (int i = 1; i <= 8; i++)
            queue_req(OP_FREE, 2, 5 * i);
        wait_drained();

        // Shrink the target under a full stack: spill all but one
        write_fill_target(3'd1);
        @(negedge clk);
        queue_req(OP_FREE, 2, 45);
        queue_req(OP_ALLOC, 3, 0);
        wait_drained();

        // Random bursts over each fill setting and idle mix
        for (p = 0; p < 8; p++)
        begin
            write_fill_target(fill_plan[p]);
            @(negedge clk);
            if (p < 3)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 52;
            end
            else if (p < 6)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_random(200);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d requests over %0d fill settings, %0d responses checked",
                 accepted_total, fill_settings, responses_seen);
        $display("saw %0d refills, %0d spills, %0d failed allocs, %0d rejected frees",
                 refills, spills, failed_allocs, rejected_frees);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
